// ----- hw/rtl/rsnp_pkg.sv -----
// rsnp_pkg: widths, constants and record types shared by the nearest-hit picker
// holds the queue entry and queue status types used by the front, queue and back
// depends on nothing
package rsnp_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int DIR_W      = 18;
   localparam int RAD_W      = 31;
   localparam int IDX_W      = 4;
   localparam int DIST_OUT_W = 63;

   // derived datapath widths
   localparam int V_W    = COORD_W + 1;               // origin - center, signed
   localparam int SQ_W   = 2 * COORD_W - FRAC_BITS;   // one shifted square
   localparam int DIST_W = SQ_W + 2;                  // sum of three squares
   localparam int R2_W   = 2 * RAD_W - FRAC_BITS;     // shifted radius square
   localparam int C_W    = DIST_W + 1;                // dist - r2, signed
   localparam int C4_W   = C_W + 2;                   // 4 * c, signed
   localparam int DP_W   = DIR_W + V_W;               // one d * v product
   localparam int DOT_W  = DP_W + 2;                  // sum of three products
   localparam int B_W    = DOT_W - FRAC_BITS + 1;     // floor(2 * dot / 2^F)
   localparam int BX_W   = (B_W + 1 > V_W + 1) ? B_W + 1 : V_W + 1;

   // decoupling queue, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one axis of a classified request
   typedef struct packed {
      logic signed [V_W-1:0]   v;
      logic [V_W-1:0]          mag;
      logic signed [DIR_W-1:0] dir;
   } rsnp_axis_type;

   // classified request as it waits for the back end
   typedef struct packed {
      rsnp_axis_type [2:0] axis;
      logic [R2_W-1:0]     r2;
      logic [IDX_W-1:0]    index;
      logic                last;
   } rsnp_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } rsnp_qstat_type;

endpackage

// ----- hw/rtl/rsnp_front.sv -----
// rsnp_front: accepts a request, forms origin - center, its magnitude and r^2
// writes the classified request into the decoupling queue
// depends on rsnp_pkg
module rsnp_front (
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_x,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_y,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_z,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_x,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_y,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_z,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_x,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_y,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_z,
   input  logic [rsnp_pkg::RAD_W-1:0]          req_sphere_radius,
   input  logic [rsnp_pkg::IDX_W-1:0]          req_sphere_index,
   input  logic                                req_last_sphere,
   input  logic                                req_push,
   output logic                                req_full,
   input  rsnp_pkg::rsnp_qstat_type            qstat,
   output logic                                q_push,
   output rsnp_pkg::rsnp_item_type             q_item
);

   logic [rsnp_pkg::COORD_W-1:0]   org [3];
   logic [rsnp_pkg::COORD_W-1:0]   ctr [3];
   logic [2*rsnp_pkg::RAD_W-1:0]   r_prod;

   assign org[0] = req_ray_origin_x;
   assign org[1] = req_ray_origin_y;
   assign org[2] = req_ray_origin_z;
   assign ctr[0] = req_sphere_center_x;
   assign ctr[1] = req_sphere_center_y;
   assign ctr[2] = req_sphere_center_z;

   // handshake into the queue
   assign req_full = qstat.full;
   assign q_push   = req_push && !qstat.full;

   // radius square, scaled back to the fixed-point format
   assign r_prod = {{rsnp_pkg::RAD_W{1'b0}}, req_sphere_radius}
                 * {{rsnp_pkg::RAD_W{1'b0}}, req_sphere_radius};

   // per-axis difference and its magnitude, both directions in parallel
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [rsnp_pkg::V_W-1:0] pos;
         logic [rsnp_pkg::V_W-1:0] neg;
         pos = {org[k][rsnp_pkg::COORD_W-1], org[k]} - {ctr[k][rsnp_pkg::COORD_W-1], ctr[k]};
         neg = {ctr[k][rsnp_pkg::COORD_W-1], ctr[k]} - {org[k][rsnp_pkg::COORD_W-1], org[k]};
         q_item.axis[k].v   = pos;
         q_item.axis[k].mag = pos[rsnp_pkg::V_W-1] ? neg : pos;
      end
      q_item.axis[0].dir = req_ray_dir_x;
      q_item.axis[1].dir = req_ray_dir_y;
      q_item.axis[2].dir = req_ray_dir_z;
      q_item.r2          = r_prod[2*rsnp_pkg::RAD_W-1:rsnp_pkg::FRAC_BITS];
      q_item.index       = req_sphere_index;
      q_item.last        = req_last_sphere;
   end

endmodule

// ----- hw/rtl/rsnp_queue.sv -----
// rsnp_queue: short queue of classified requests between front and back end
// depends on rsnp_pkg
module rsnp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rsnp_pkg::rsnp_item_type  push_item,
   input  logic                     pop,
   output rsnp_pkg::rsnp_item_type  head_item,
   output rsnp_pkg::rsnp_qstat_type qstat
);

   rsnp_pkg::rsnp_item_type        mem_ff [rsnp_pkg::QUEUE_DEPTH];
   logic [rsnp_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rsnp_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rsnp_pkg::QPTR_W:0]      count_ff, count_in;
   logic                           do_push, do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (rsnp_pkg::QPTR_W+1)'(rsnp_pkg::QUEUE_DEPTH));
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_item   = mem_ff[rd_ptr_ff];

   // pointers wrap naturally at a power-of-two depth
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/rsnp_back.sv -----
// rsnp_back: per-sphere hit test on a shared squarer and dot-product multiplier,
// nearest-hit tracking and the result register
// depends on rsnp_pkg
module rsnp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rsnp_pkg::rsnp_item_type              item,
   input  rsnp_pkg::rsnp_qstat_type             qstat,
   output logic                                 item_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_hit_found,
   output logic [rsnp_pkg::IDX_W-1:0]           rsp_hit_index,
   output logic [rsnp_pkg::DIST_OUT_W-1:0]      rsp_hit_dist_sq
);

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_AXIS = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_BSH  = 6'b001000,
      ST_BSQ  = 6'b010000,
      ST_DEC  = 6'b100000
   } rsnp_state_type;

   // square of a magnitude up to 2^32, saturated, scaled back by the fraction
   function automatic logic [rsnp_pkg::SQ_W-1:0] sq_shift(input logic [rsnp_pkg::V_W-1:0] mag);
      logic [2*rsnp_pkg::COORD_W-1:0] p;
      if (mag[rsnp_pkg::COORD_W]) begin
         p = '1;
      end else begin
         p = {{rsnp_pkg::COORD_W{1'b0}}, mag[rsnp_pkg::COORD_W-1:0]}
           * {{rsnp_pkg::COORD_W{1'b0}}, mag[rsnp_pkg::COORD_W-1:0]};
      end
      return p[2*rsnp_pkg::COORD_W-1:rsnp_pkg::FRAC_BITS];
   endfunction

   rsnp_state_type                        state_ff, state_in;
   logic [1:0]                            axis_ff, axis_in;
   logic [rsnp_pkg::SQ_W-1:0]             sq_ff, sq_in;
   logic signed [rsnp_pkg::DP_W-1:0]      dp_ff, dp_in;
   logic [rsnp_pkg::DIST_W-1:0]           dist_ff, dist_in;
   logic signed [rsnp_pkg::DOT_W-1:0]     dot_ff, dot_in;
   logic signed [rsnp_pkg::C_W-1:0]       c_ff, c_in;
   logic [rsnp_pkg::BX_W-1:0]             bneg_ff, bneg_in;
   logic                                  best_valid_ff, best_valid_in;
   logic [rsnp_pkg::IDX_W-1:0]            best_index_ff, best_index_in;
   logic [rsnp_pkg::DIST_W-1:0]           best_dist_ff, best_dist_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_found_ff, rsp_found_in;
   logic [rsnp_pkg::IDX_W-1:0]            rsp_index_ff, rsp_index_in;
   logic [rsnp_pkg::DIST_W-1:0]           rsp_dist_ff, rsp_dist_in;

   rsnp_pkg::rsnp_axis_type               sel;
   logic [rsnp_pkg::B_W-1:0]              b_val;
   logic [rsnp_pkg::BX_W-1:0]             b_ext;
   logic [rsnp_pkg::V_W-1:0]              bmag;
   logic signed [rsnp_pkg::C4_W-1:0]      bb, c4;
   logic                                  hit, closer, upd, rsp_room, done;
   logic                                  sel_valid;
   logic [rsnp_pkg::IDX_W-1:0]            sel_index;
   logic [rsnp_pkg::DIST_W-1:0]           sel_dist;

   // operand select for the shared multipliers
   always_comb begin
      case (axis_ff)
         AXIS_X:  sel = item.axis[0];
         AXIS_Y:  sel = item.axis[1];
         AXIS_Z:  sel = item.axis[2];
         default: sel = item.axis[0];
      endcase
   end

   // b = floor(2 * dot / 2^F), its negation, and its magnitude clamped for the squarer
   assign b_val = dot_ff[rsnp_pkg::DOT_W-1:rsnp_pkg::FRAC_BITS-1];
   assign b_ext = {{(rsnp_pkg::BX_W-rsnp_pkg::B_W){b_val[rsnp_pkg::B_W-1]}}, b_val};
   assign bmag  = (|bneg_ff[rsnp_pkg::BX_W-2:rsnp_pkg::COORD_W])
                ? {1'b1, {rsnp_pkg::COORD_W{1'b0}}}
                : {1'b0, bneg_ff[rsnp_pkg::COORD_W-1:0]};

   // hit test: b <= 0, c >= 0 and b^2 >= 4c
   assign bb  = {{(rsnp_pkg::C4_W-rsnp_pkg::SQ_W){1'b0}}, sq_ff};
   assign c4  = {c_ff, 2'b00};
   assign hit = !bneg_ff[rsnp_pkg::BX_W-1] && !c_ff[rsnp_pkg::C_W-1] && (bb >= c4);

   // nearest so far, the earlier of equal distances stays
   assign closer = !best_valid_ff || (dist_ff < best_dist_ff);
   assign upd    = hit && closer;

   assign sel_valid = upd || best_valid_ff;
   assign sel_index = upd ? item.index : best_index_ff;
   assign sel_dist  = upd ? dist_ff : best_dist_ff;

   assign rsp_room = !rsp_valid_ff || rsp_pop;
   assign done     = (state_ff == ST_DEC) && (!item.last || rsp_room);
   assign item_pop = done;

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      sq_in         = sq_ff;
      dp_in         = dp_ff;
      dist_in       = dist_ff;
      dot_in        = dot_ff;
      c_in          = c_ff;
      bneg_in       = bneg_ff;
      best_valid_in = best_valid_ff;
      best_index_in = best_index_ff;
      best_dist_in  = best_dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;

      case (state_ff)
         ST_IDLE: begin
            axis_in = AXIS_X;
            if (!qstat.empty) begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            // products of this axis, sums of the previous one
            sq_in = sq_shift(sel.mag);
            dp_in = sel.v * sel.dir;
            if (axis_ff == AXIS_X) begin
               dist_in = '0;
               dot_in  = '0;
            end else begin
               dist_in = dist_ff + {2'b00, sq_ff};
               dot_in  = dot_ff + {{2{dp_ff[rsnp_pkg::DP_W-1]}}, dp_ff};
            end
            if (axis_ff == AXIS_Z) begin
               state_in = ST_ACC;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_ACC: begin
            dist_in  = dist_ff + {2'b00, sq_ff};
            dot_in   = dot_ff + {{2{dp_ff[rsnp_pkg::DP_W-1]}}, dp_ff};
            state_in = ST_BSH;
         end
         ST_BSH: begin
            c_in     = $signed({1'b0, dist_ff})
                     - $signed({{(rsnp_pkg::C_W-rsnp_pkg::R2_W){1'b0}}, item.r2});
            bneg_in  = (~b_ext) + {{(rsnp_pkg::BX_W-1){1'b0}}, 1'b1};
            state_in = ST_BSQ;
         end
         ST_BSQ: begin
            sq_in    = sq_shift(bmag);
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (done) begin
               state_in = ST_IDLE;
               if (item.last) begin
                  // emit the pick and start a fresh set
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = sel_valid;
                  rsp_index_in  = sel_index;
                  rsp_dist_in   = sel_dist;
                  best_valid_in = 1'b0;
                  best_index_in = '0;
                  best_dist_in  = '0;
               end else if (upd) begin
                  best_valid_in = 1'b1;
                  best_index_in = item.index;
                  best_dist_in  = dist_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= AXIS_X;
         best_valid_ff <= 1'b0;
         best_index_ff <= '0;
         best_dist_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         best_valid_ff <= best_valid_in;
         best_index_ff <= best_index_in;
         best_dist_ff  <= best_dist_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      dp_ff        <= dp_in;
      dist_ff      <= dist_in;
      dot_ff       <= dot_in;
      c_ff         <= c_in;
      bneg_ff      <= bneg_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_hit_found   = rsp_found_ff;
   assign rsp_hit_index   = rsp_index_ff;
   assign rsp_hit_dist_sq = {{(rsnp_pkg::DIST_OUT_W-rsnp_pkg::DIST_W){1'b0}}, rsp_dist_ff};

endmodule

// ----- hw/rtl/ray_sphere_nearest_pick_top.sv -----
// ray_sphere_nearest_pick_top: nearest ray-sphere hit over a run of spheres, uses rsnp_pkg
// and the rsnp_front, rsnp_queue and rsnp_back modules
// The back end works on one sphere at a time and shares one squarer and one dot-product
// multiplier over the three axes and b^2. The queue holds 2 requests, the one in the back end
// included; a waiting result holds the next last sphere. Synchronous reset clears the control
// and tracked state; the datapath, result payload and queue entries are not reset.
module ray_sphere_nearest_pick_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_x,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_y,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_z,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_x,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_y,
   input  logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_z,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_x,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_y,
   input  logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_z,
   input  logic [rsnp_pkg::RAD_W-1:0]          req_sphere_radius,
   input  logic [rsnp_pkg::IDX_W-1:0]          req_sphere_index,
   input  logic                                req_last_sphere,
   input  logic                                req_push,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_hit_found,
   output logic [rsnp_pkg::IDX_W-1:0]          rsp_hit_index,
   output logic [rsnp_pkg::DIST_OUT_W-1:0]     rsp_hit_dist_sq
);

   rsnp_pkg::rsnp_qstat_type qstat;
   rsnp_pkg::rsnp_item_type  q_item;
   rsnp_pkg::rsnp_item_type  head_item;
   logic                     q_push;
   logic                     q_pop;

   // request intake and classification
   rsnp_front u_front (
      .req_ray_origin_x    (req_ray_origin_x),
      .req_ray_origin_y    (req_ray_origin_y),
      .req_ray_origin_z    (req_ray_origin_z),
      .req_ray_dir_x       (req_ray_dir_x),
      .req_ray_dir_y       (req_ray_dir_y),
      .req_ray_dir_z       (req_ray_dir_z),
      .req_sphere_center_x (req_sphere_center_x),
      .req_sphere_center_y (req_sphere_center_y),
      .req_sphere_center_z (req_sphere_center_z),
      .req_sphere_radius   (req_sphere_radius),
      .req_sphere_index    (req_sphere_index),
      .req_last_sphere     (req_last_sphere),
      .req_push            (req_push),
      .req_full            (req_full),
      .qstat               (qstat),
      .q_push              (q_push),
      .q_item              (q_item)
   );

   // decoupling queue
   rsnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // hit test, nearest tracking, result register
   rsnp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (head_item),
      .qstat           (qstat),
      .item_pop        (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hit_found   (rsp_hit_found),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_hit_dist_sq (rsp_hit_dist_sq)
   );

endmodule

// ----- hw/rtl/rsnp_checker.sv -----
// rsnp_checker: port-level checks on the nearest-hit picker, bound to the top level
// depends on rsnp_pkg and ray_sphere_nearest_pick_top
module rsnp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_x,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_y,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_ray_origin_z,
   input logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_x,
   input logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_y,
   input logic signed [rsnp_pkg::DIR_W-1:0]   req_ray_dir_z,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_x,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_y,
   input logic signed [rsnp_pkg::COORD_W-1:0] req_sphere_center_z,
   input logic [rsnp_pkg::RAD_W-1:0]          req_sphere_radius,
   input logic [rsnp_pkg::IDX_W-1:0]          req_sphere_index,
   input logic                                req_last_sphere,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic                                rsp_hit_found,
   input logic [rsnp_pkg::IDX_W-1:0]          rsp_hit_index,
   input logic [rsnp_pkg::DIST_OUT_W-1:0]     rsp_hit_dist_sq
);

   // reset leaves no result pending and room for requests
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("rsnp: not empty or full after reset");

   // a pending result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hit_found)
         && $stable(rsp_hit_index) && $stable(rsp_hit_dist_sq)))
      else $error("rsnp: result changed while waiting");

   // no pick reports zero index and distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_hit_found) |-> (rsp_hit_index == '0 && rsp_hit_dist_sq == '0))
      else $error("rsnp: miss with nonzero index or distance");

   // the distance of a pick never needs more than the datapath width
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hit_dist_sq[rsnp_pkg::DIST_OUT_W-1:rsnp_pkg::DIST_W] == '0))
      else $error("rsnp: distance out of range");

endmodule

bind ray_sphere_nearest_pick_top rsnp_checker u_rsnp_checker (.*);
